// ===== rtl/lmid_pkg.sv =====
// Shared widths and constants for the triangular lattice minimum-image distance pipeline.
package lmid_pkg;

	localparam int MAX_LOG2_SIDE = 10;
	localparam int LOG2_W        = 4;
	localparam int SITE_W        = 20;
	localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(6);
	localparam logic [LOG2_W-1:0] LOG2_MIN   = LOG2_W'(1);
	localparam logic [LOG2_W-1:0] LOG2_MAX   = LOG2_W'(MAX_LOG2_SIDE);

	localparam int COORD_W = MAX_LOG2_SIDE;      // row / column
	localparam int SIDE_W  = MAX_LOG2_SIDE + 1;  // side length
	localparam int DY_W    = COORD_W + 1;        // signed row difference
	localparam int TDX_W   = COORD_W + 3;        // signed doubled skewed column difference
	localparam int OFF_W   = SIDE_W + 2;         // signed mirror offsets (up to 3S-1)
	localparam int A_W     = TDX_W + 1;          // image twodx
	localparam int B_W     = DY_W + 2;           // image dy
	localparam int ASQ_W   = 2 * A_W - 2;
	localparam int BSQ_W   = 2 * B_W - 3;
	localparam int SEP_W   = ASQ_W + 1;
	localparam int OUT_SEP_W = 24;
	localparam int NIMG    = 4;                  // direct image plus up to three mirrors

	// distance_q8 = isqrt(sep * 2^13), one root bit per stage
	localparam int ROOT_W = 19;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int PAD_W  = RAD_W - 1 - OUT_SEP_W;

endpackage

// ===== rtl/lattice_min_image_distance.sv =====
// Top level: pipelined minimum-image squared separation and Q.8 distance on a triangular lattice.
//
// Takes one site pair per cycle (busy stays low) and returns one result per pair, in order,
// as a single-cycle done strobe; the receiver cannot stall and the pipeline never does either.
// Six stages decode the sites and find the nearest image: row and column split, mirror choice
// from the signs of twodx-dy and dy and whether |dy| exceeds 1, squares of the four candidate
// images, their separations, and a two-level minimum tree. Nineteen further stages
// each produce one bit of floor(256*sqrt(sep/8)) by digit recurrence, so the square root sets
// the latency while every stage still takes a new word each cycle. The lattice size register
// is held at its saturated value (1..10); its write channel is ready only while no word is in
// flight.
module lattice_min_image_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [lmid_pkg::SITE_W-1:0]         first_site,
	input  logic [lmid_pkg::SITE_W-1:0]         second_site,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lmid_pkg::LOG2_W-1:0]         cfg_data,
	output logic                                done,
	output logic [lmid_pkg::OUT_SEP_W-1:0]      min_sep_squared,
	output logic [lmid_pkg::ROOT_W-1:0]         distance_q8
);
	import lmid_pkg::*;

	// ---------------------------------------------------------------- config
	logic [LOG2_W-1:0] log2_q;
	logic [LOG2_W-1:0] log2_sat;
	logic              inflight;

	always_comb begin
		if (cfg_data < LOG2_MIN) begin
			log2_sat = LOG2_MIN;
		end else if (cfg_data > LOG2_MAX) begin
			log2_sat = LOG2_MAX;
		end else begin
			log2_sat = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= LOG2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			log2_q <= log2_sat;
		end
	end

	assign busy      = 1'b0;
	assign cfg_ready = !inflight;

	// ---------------------------------------------------------------- stage 1: split sites
	logic [SIDE_W-1:0]         side_c;
	logic [COORD_W-1:0]        mask_c;
	logic [SITE_W-1:0]         sh1_c, sh2_c;
	logic [COORD_W-1:0]        r1_c, r2_c, c1_c, c2_c;
	logic signed [DY_W-1:0]    dy_c, dc_c;
	logic signed [TDX_W-1:0]   tdx_c;

	always_comb begin
		side_c = SIDE_W'(1) << log2_q;
		mask_c = COORD_W'(side_c - SIDE_W'(1));
		sh1_c  = first_site >> log2_q;
		sh2_c  = second_site >> log2_q;
		r1_c   = sh1_c[COORD_W-1:0] & mask_c;
		r2_c   = sh2_c[COORD_W-1:0] & mask_c;
		c1_c   = first_site[COORD_W-1:0] & mask_c;
		c2_c   = second_site[COORD_W-1:0] & mask_c;
		dy_c   = $signed({1'b0, r2_c}) - $signed({1'b0, r1_c});
		dc_c   = $signed({1'b0, c2_c}) - $signed({1'b0, c1_c});
		tdx_c  = $signed({dc_c[DY_W-1], dc_c, 1'b0}) + $signed({{2{dy_c[DY_W-1]}}, dy_c});
	end

	logic                    v_s1;
	logic signed [DY_W-1:0]  dy_s1;
	logic signed [TDX_W-1:0] tdx_s1;
	logic [SIDE_W-1:0]       side_s1;

	// ---------------------------------------------------------------- stage 2: pick mirrors
	logic signed [OFF_W-1:0] sx, ax, bx, cx, dx, ay, by, cy, dyo;
	logic signed [OFF_W-1:0] ox [NIMG];
	logic signed [OFF_W-1:0] oy [NIMG];
	logic signed [TDX_W-1:0] t_c;
	logic                    t_pos, t_neg, dy_pos, dy_neg, dy_gt1, dy_ltm1;
	logic signed [A_W-1:0]   a_c [NIMG];
	logic signed [B_W-1:0]   b_c [NIMG];

	always_comb begin
		sx  = $signed({2'b00, side_s1});
		ax  = sx;
		ay  = sx;
		bx  = (sx <<< 1) + sx - OFF_W'(1);
		by  = sx - OFF_W'(1);
		cx  = (sx <<< 1) - OFF_W'(1);
		cy  = -OFF_W'(1);
		dx  = sx - OFF_W'(1);
		dyo = -sx - OFF_W'(1);

		t_c     = tdx_s1 - $signed({{2{dy_s1[DY_W-1]}}, dy_s1});
		t_neg   = t_c[TDX_W-1];
		t_pos   = !t_c[TDX_W-1] && (t_c != '0);
		dy_neg  = dy_s1[DY_W-1];
		dy_pos  = !dy_s1[DY_W-1] && (dy_s1 != '0);
		dy_gt1  = dy_s1 > DY_W'(1);
		dy_ltm1 = dy_s1 < -DY_W'(1);

		for (int i = 0; i < NIMG; i++) begin
			ox[i] = '0;
			oy[i] = '0;
		end

		if (t_pos) begin
			if (dy_pos) begin
				ox[1] = -ax; oy[1] = -ay;
				ox[2] = -bx; oy[2] = -by;
				ox[3] = -cx; oy[3] = -cy;
			end else if (dy_ltm1) begin
				ox[1] = ax;  oy[1] = ay;
				ox[2] = -cx; oy[2] = -cy;
				ox[3] = -dx; oy[3] = -dyo;
			end else begin
				ox[1] = -cx; oy[1] = -cy;
			end
		end else if (t_neg) begin
			if (dy_gt1) begin
				ox[1] = -ax; oy[1] = -ay;
				ox[2] = cx;  oy[2] = cy;
				ox[3] = dx;  oy[3] = dyo;
			end else if (dy_neg) begin
				ox[1] = ax;  oy[1] = ay;
				ox[2] = bx;  oy[2] = by;
				ox[3] = cx;  oy[3] = cy;
			end else begin
				ox[1] = cx;  oy[1] = cy;
			end
		end else begin
			if (dy_pos) begin
				ox[1] = -ax; oy[1] = -ay;
			end else begin
				ox[1] = ax;  oy[1] = ay;
			end
		end

		// unused lanes keep a zero offset and so repeat the direct image
		for (int i = 0; i < NIMG; i++) begin
			a_c[i] = $signed({tdx_s1[TDX_W-1], tdx_s1})
				+ $signed({ox[i][OFF_W-1], ox[i]});
			b_c[i] = $signed({{2{dy_s1[DY_W-1]}}, dy_s1}) + oy[i];
		end
	end

	logic                  v_s2;
	logic signed [A_W-1:0] a_s2 [NIMG];
	logic signed [B_W-1:0] b_s2 [NIMG];

	// ---------------------------------------------------------------- stage 3: squares
	logic signed [2*A_W-1:0] asq_c [NIMG];
	logic signed [2*B_W-1:0] bsq_c [NIMG];

	always_comb begin
		for (int i = 0; i < NIMG; i++) begin
			asq_c[i] = a_s2[i] * a_s2[i];
			bsq_c[i] = b_s2[i] * b_s2[i];
		end
	end

	logic             v_s3;
	logic [ASQ_W-1:0] asq_s3 [NIMG];
	logic [BSQ_W-1:0] bsq_s3 [NIMG];

	// ---------------------------------------------------------------- stage 4: separations
	logic [SEP_W-1:0] sep_c [NIMG];

	always_comb begin
		for (int i = 0; i < NIMG; i++) begin
			sep_c[i] = SEP_W'(asq_s3[i]) + SEP_W'(bsq_s3[i]) + SEP_W'({bsq_s3[i], 1'b0});
		end
	end

	logic             v_s4;
	logic [SEP_W-1:0] sep_s4 [NIMG];

	// ---------------------------------------------------------------- stages 5, 6: min tree
	logic             v_s5;
	logic [SEP_W-1:0] m0_s5, m1_s5;
	logic             v_s6;
	logic [OUT_SEP_W-1:0] best_s6;
	logic [SEP_W-1:0] best_c;

	// the minimum never exceeds the direct image, which fits the output width
	assign best_c = (m1_s5 < m0_s5) ? m1_s5 : m0_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		dy_s1   <= dy_c;
		tdx_s1  <= tdx_c;
		side_s1 <= side_c;
		for (int i = 0; i < NIMG; i++) begin
			a_s2[i]   <= a_c[i];
			b_s2[i]   <= b_c[i];
			asq_s3[i] <= asq_c[i][ASQ_W-1:0];
			bsq_s3[i] <= bsq_c[i][BSQ_W-1:0];
			sep_s4[i] <= sep_c[i];
		end
		m0_s5   <= (sep_s4[1] < sep_s4[0]) ? sep_s4[1] : sep_s4[0];
		m1_s5   <= (sep_s4[3] < sep_s4[2]) ? sep_s4[3] : sep_s4[2];
		best_s6 <= best_c[OUT_SEP_W-1:0];
	end

	// ---------------------------------------------------------------- root stages
	// Restoring square root of {sep, 13 zero bits}, two radicand bits per stage.
	logic                 rt_v_s    [ROOT_W];
	logic [RAD_W-1:0]     rt_rad_s  [ROOT_W];
	logic [REM_W-1:0]     rt_rem_s  [ROOT_W];
	logic [ROOT_W-1:0]    rt_root_s [ROOT_W];
	logic [OUT_SEP_W-1:0] rt_sep_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic                 v_in;
		logic [RAD_W-1:0]     rad_in;
		logic [REM_W-1:0]     rem_in;
		logic [ROOT_W-1:0]    root_in;
		logic [OUT_SEP_W-1:0] sep_in;
		logic [REM_W+1:0]     cand, trial, diff;
		logic                 ge;

		if (k == 0) begin : g_head
			assign v_in    = v_s6;
			assign rad_in  = {1'b0, best_s6, PAD_W'(0)};
			assign rem_in  = '0;
			assign root_in = '0;
			assign sep_in  = best_s6;
		end else begin : g_body
			assign v_in    = rt_v_s[k-1];
			assign rad_in  = rt_rad_s[k-1];
			assign rem_in  = rt_rem_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign sep_in  = rt_sep_s[k-1];
		end

		assign cand  = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cand >= trial;
		assign diff  = cand - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k] <= 1'b0;
			end else begin
				rt_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rt_rad_s[k]  <= rad_in << 2;
			rt_rem_s[k]  <= ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
			rt_root_s[k] <= {root_in[ROOT_W-2:0], ge};
			rt_sep_s[k]  <= sep_in;
		end
	end

	// ---------------------------------------------------------------- occupancy
	always_comb begin
		inflight = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;
		for (int k = 0; k < ROOT_W; k++) begin
			inflight = inflight | rt_v_s[k];
		end
	end

	assign done            = rt_v_s[ROOT_W-1];
	assign min_sep_squared = rt_sep_s[ROOT_W-1];
	assign distance_q8     = rt_root_s[ROOT_W-1];

endmodule
